// ----- rtl/fm_quadrature_demodulator_top_macros.svh -----
// Assertion macros shared by the checker.
`ifndef FM_QUADRATURE_DEMODULATOR_TOP_MACROS_SVH
`define FM_QUADRATURE_DEMODULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FMQD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmqd check failed");

// Next-cycle implication, disabled during reset.
`define FMQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmqd check failed");

`endif

// ----- rtl/fmqd_pkg.sv -----
package fmqd_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_STEPS       = 24;
  localparam int CORDIC_STEPS     = (ANGLE_ITERATIONS > ATAN_STEPS) ? ATAN_STEPS
                                                                     : ANGLE_ITERATIONS;
  // x/y headroom: negation plus CORDIC gain of about 1.65 * sqrt(2)
  localparam int DP_W     = SAMPLE_WIDTH + 4;
  localparam int STEP_W   = $clog2(ATAN_STEPS);
  localparam int Z_W      = 32;
  localparam int ANGLE_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int DEMOD_W  = 16;
  localparam int GAIN_FRAC = 12;
  localparam int PROD_W   = ANGLE_W + GAIN_W + 1;

  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd4096;
  localparam logic [Z_W-1:0]     Z_PI       = 32'h8000_0000;
  localparam logic [Z_W-1:0]     Z_ROUND    = 32'h0000_8000;
  localparam logic [DEMOD_W-1:0] DEMOD_MAX  = 16'h7FFF;
  localparam logic [DEMOD_W-1:0] DEMOD_MIN  = 16'h8000;

  // atan(2^-k), 2^31 = pi
  localparam logic [Z_W-1:0] ATAN_TAB [ATAN_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic               done;
    logic [ANGLE_W-1:0] angle;
  } fmqd_ang_t;

  typedef struct packed {
    logic               done;
    logic [DEMOD_W-1:0] demod;
  } fmqd_res_t;

endpackage

// ----- rtl/fmqd_cordic.sv -----
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
module fmqd_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0] samp_i,
  input  logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0] samp_q,
  output fmqd_pkg::fmqd_ang_t                 ang
);
  import fmqd_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic signed [DP_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [DP_W-1:0] xs, ys, ext_i, ext_q;
  logic [Z_W-1:0]         z_r, z_nxt, z_rnd;
  logic [STEP_W-1:0]      k_r;
  logic                   busy_r, done_r, zero_r;

  assign ext_i = DP_W'(samp_i);
  assign ext_q = DP_W'(samp_q);

  // shared shift/add step
  assign xs = x_r >>> k_r;
  assign ys = y_r >>> k_r;

  always_comb begin
    if (!y_r[DP_W-1]) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + ATAN_TAB[k_r];
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - ATAN_TAB[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      // one-cycle pulse after the last rotation
      done_r <= busy_r && !start && (k_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (samp_i == '0) && (samp_q == '0);
      // left half plane: pre-rotate by pi
      if (samp_i[SAMPLE_WIDTH-1]) begin
        x_r <= -ext_i;
        y_r <= -ext_q;
        z_r <= Z_PI;
      end else begin
        x_r <= ext_i;
        y_r <= ext_q;
        z_r <= '0;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign z_rnd     = z_r + Z_ROUND;
  assign ang.done  = done_r;
  assign ang.angle = zero_r ? '0 : z_rnd[Z_W-1:Z_W-ANGLE_W];

endmodule

// ----- rtl/fmqd_scale.sv -----
// Phase difference, gain multiply, shift and saturate, registered in prod_r and then demod_r.
module fmqd_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fmqd_pkg::fmqd_ang_t           ang,
  input  logic [fmqd_pkg::GAIN_W-1:0]   gain,
  output fmqd_pkg::fmqd_res_t           res
);
  import fmqd_pkg::*;

  logic [ANGLE_W-1:0]        prev_angle_r, diff;
  logic signed [PROD_W-1:0]  prod_r, prod_sh;
  logic [PROD_W-DEMOD_W:0]   hi;
  logic [DEMOD_W-1:0]        demod_r, demod_nxt;
  logic                      mul_v_r, done_r;

  // wrap in two's complement keeps the step in [-pi, pi)
  assign diff = ang.angle - prev_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= '0;
      mul_v_r      <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      mul_v_r <= ang.done;
      done_r  <= mul_v_r;
      if (ang.done) prev_angle_r <= ang.angle;
    end
  end

  // saturate to signed 16 bits
  assign prod_sh = prod_r >>> GAIN_FRAC;
  assign hi      = prod_sh[PROD_W-1:DEMOD_W-1];

  always_comb begin
    if ((hi == '0) || (hi == '1)) demod_nxt = prod_sh[DEMOD_W-1:0];
    else if (prod_sh[PROD_W-1])   demod_nxt = DEMOD_MIN;
    else                          demod_nxt = DEMOD_MAX;
  end

  always_ff @(posedge clk) begin
    if (ang.done) prod_r <= PROD_W'($signed(diff)) * PROD_W'($signed({1'b0, gain}));
    if (mul_v_r)  demod_r <= demod_nxt;
  end

  assign res.done  = done_r;
  assign res.demod = demod_r;

endmodule

// ----- rtl/fm_quadrature_demodulator_top.sv -----
// An accepted sample passes the iterative CORDIC, rotating one step per cycle,
// then prod_r and demod_r in the scale stage and the output register; no new
// sample is taken (in_ready low) until the result reaches the output register.
// Reset (rst_n, synchronous, active low) clears the previous angle, sets
// gain_r to 4096 and drops all valids.
module fm_quadrature_demodulator_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0] in_q,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fmqd_pkg::DEMOD_W-1:0]    out_demod,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fmqd_pkg::GAIN_W-1:0]            cfg_data
);
  import fmqd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_HOLD} state_t;

  state_t             state_r;
  logic               out_valid_r;
  logic [DEMOD_W-1:0] out_demod_r;
  logic [GAIN_W-1:0]  gain_r;
  logic               in_acc, out_free, out_load;
  fmqd_ang_t          ang;
  fmqd_res_t          res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  // result moves to the output register when it is ready and the register frees
  assign out_load  = out_free && (((state_r == S_BUSY) && res.done) || (state_r == S_HOLD));

  fmqd_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .samp_i (in_i),
    .samp_q (in_q),
    .ang    (ang)
  );

  fmqd_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .ang   (ang),
    .gain  (gain_r),
    .res   (res)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) gain_r <= cfg_data;
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_demod_r <= res.demod;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) state_r <= S_BUSY;
        end
        S_BUSY: begin
          if (res.done) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          // result waits in the scale stage until the output register frees
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_demod = out_demod_r;

endmodule

// ----- rtl/fmqd_checker.sv -----
`include "fm_quadrature_demodulator_top_macros.svh"

// Port-level checks for the demodulator.
module fmqd_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [fmqd_pkg::DEMOD_W-1:0]    out_demod,
  input logic                                   cfg_valid,
  input logic                                   cfg_ready
);
  import fmqd_pkg::*;

  // stalled result holds
  `FMQD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_demod))

  // one transaction in flight: busy right after an accept
  `FMQD_ASSERT_NEXT(a_busy_after_acc, in_valid && in_ready, !in_ready)

  // a result cannot appear the cycle after an accept
  `FMQD_ASSERT_NEXT(a_no_early_out, in_valid && in_ready, !$rose(out_valid))

  // configuration is always taken
  `FMQD_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind fm_quadrature_demodulator_top fmqd_checker u_fmqd_checker (.*);

// ----- test/fm_quadrature_demodulator_top_tb.sv -----
module fm_quadrature_demodulator_top_tb;

  localparam int  SW           = fmqd_pkg::SAMPLE_WIDTH;
  localparam int  DW           = fmqd_pkg::DEMOD_W;
  localparam int  GW           = fmqd_pkg::GAIN_W;
  localparam int  DRAIN_CYCLES = fmqd_pkg::CORDIC_STEPS + 12;
  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  ATAN_MAX     = 24;
  localparam real PI           = 3.14159265358979;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] in_i      = '0;
  logic signed [SW-1:0] in_q      = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] out_demod;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [GW-1:0]        cfg_data  = '0;

  // Predictor state, mirrors the block
  bit [15:0]            last_phase = '0;
  bit [GW-1:0]          gain_reg   = 16'd4096;
  logic signed [DW-1:0] exp_demod_q[$];
  logic signed [DW-1:0] want_demod;

  int  error_count     = 0;
  int  samples_sent    = 0;
  int  results_checked = 0;
  int  gains_used      = 0;
  int  cycle_count     = 0;
  int  hold_left       = 0;
  bit  idle_en         = 1'b1;

  // Phasor generator state for FM-like streams
  real ph      = 0.0;
  real ph_step = 0.1;
  real amp     = 20000.0;

  fm_quadrature_demodulator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_i      (in_i),
    .in_q      (in_q),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_demod (out_demod),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // atan(2^-k) with 2^31 = pi
  function automatic bit [31:0] atan_step(input int k);
    case (k)
      0:  return 32'h20000000;   1: return 32'h12E4051E;
      2:  return 32'h09FB385B;   3: return 32'h051111D4;
      4:  return 32'h028B0D43;   5: return 32'h0145D7E1;
      6:  return 32'h00A2F61E;   7: return 32'h00517C55;
      8:  return 32'h0028BE53;   9: return 32'h00145F2F;
      10: return 32'h000A2F98;  11: return 32'h000517CC;
      12: return 32'h00028BE6;  13: return 32'h000145F3;
      14: return 32'h0000A2FA;  15: return 32'h0000517D;
      16: return 32'h000028BE;  17: return 32'h0000145F;
      18: return 32'h00000A30;  19: return 32'h00000518;
      20: return 32'h0000028C;  21: return 32'h00000146;
      22: return 32'h000000A3;  default: return 32'h00000051;
    endcase
  endfunction

  // Vectoring CORDIC, binary angle with 32768 = pi
  function automatic bit [15:0] cordic_phase(input longint x, input longint y);
    bit [31:0] z;
    longint    xs, ys;
    int        steps, k;
    z = '0;
    steps = (fmqd_pkg::ANGLE_ITERATIONS > ATAN_MAX) ? ATAN_MAX
                                                    : fmqd_pkg::ANGLE_ITERATIONS;
    if (x == 0 && y == 0) return '0;
    // left half plane: pre-rotate by pi
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (k = 0; k < steps; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(k);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(k);
      end
    end
    z = z + 32'h0000_8000;
    return z[31:16];
  endfunction

  // Phase step since the last sample, scaled by the gain and saturated
  function automatic logic signed [DW-1:0] predict_demod(input logic signed [SW-1:0] si,
                                                         input logic signed [SW-1:0] sq);
    bit [15:0]         phase;
    logic signed [15:0] dphase;
    longint            scaled;
    phase  = cordic_phase(longint'(si), longint'(sq));
    dphase = phase - last_phase;
    scaled = (longint'(dphase) * longint'(gain_reg)) >>> 12;
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    last_phase = phase;
    return scaled[DW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Monitor: checks results, tracks gain writes, predicts each accepted sample
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (exp_demod_q.size() == 0) begin
          report_mismatch($sformatf("demod %0d with no transaction expected", out_demod));
        end else begin
          want_demod = exp_demod_q.pop_front();
          if (out_demod !== want_demod)
            report_mismatch($sformatf("demod got %0d want %0d (result %0d)",
                                      out_demod, want_demod, results_checked));
        end
      end
      if (cfg_valid && cfg_ready) gain_reg = cfg_data;
      if (in_valid && in_ready) begin
        exp_demod_q.push_back(predict_demod(in_i, in_q));
        samples_sent++;
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !(idle_en && ($urandom_range(99) < 9));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, exp_demod_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // One input transaction; valid stays high into the next call if no gap
  task automatic send_sample(input logic signed [SW-1:0] si, input logic signed [SW-1:0] sq);
    @(negedge clk);
    while (idle_en && ($urandom_range(99) < 9)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_i     <= si;
    in_q     <= sq;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic end_stream();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (exp_demod_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GW-1:0] g);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gains_used++;
  endtask

  function automatic logic signed [SW-1:0] edge_value();
    case ($urandom_range(4))
      0:       return SW'(-32768);
      1:       return SW'(-1);
      2:       return SW'(0);
      3:       return SW'(1);
      default: return SW'(32767);
    endcase
  endfunction

  // Mix of FM-like phasor, full random, tiny and edge samples
  task automatic next_sample(output logic signed [SW-1:0] si, output logic signed [SW-1:0] sq);
    int kind;
    kind = $urandom_range(99);
    if (kind < 50) begin
      if ($urandom_range(31) == 0) begin
        amp     = real'($urandom_range(32767));
        ph_step = (real'($urandom_range(2000)) - 1000.0) / 1000.0 * PI;
      end
      ph = ph + ph_step;
      if (ph > PI) ph = ph - 2.0 * PI;
      if (ph < -PI) ph = ph + 2.0 * PI;
      si = SW'($rtoi(amp * $cos(ph)));
      sq = SW'($rtoi(amp * $sin(ph)));
    end else if (kind < 75) begin
      si = SW'($urandom);
      sq = SW'($urandom);
    end else if (kind < 87) begin
      si = SW'(int'($urandom_range(8)) - 4);
      sq = SW'(int'($urandom_range(8)) - 4);
    end else begin
      si = edge_value();
      sq = edge_value();
    end
  endtask

  // Axis, zero, corner and wrap samples under the reset gain
  task automatic test_directed_samples();
    send_sample(0, 0);
    send_sample(32767, 0);
    send_sample(-32768, 0);
    send_sample(0, 32767);
    send_sample(0, -32768);
    send_sample(-32768, -32768);
    send_sample(32767, 32767);
    send_sample(-1, 0);
    send_sample(-1, -1);
    send_sample(1, -1);
    send_sample(-32768, 1);
    send_sample(-32768, -1);
    send_sample(0, 0);
    send_sample(32767, -32768);
    send_sample(-32768, 32767);
    send_sample(1, 1);
    send_sample(0, 0);
    end_stream();
  endtask

  // Gain extremes and a few mid values, random samples each
  task automatic test_gain_settings();
    logic [GW-1:0]        gains[7];
    logic signed [SW-1:0] si, sq;
    gains = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'd4096, 16'hFFFF, 16'h0000};
    gains[5] = GW'($urandom);
    for (int g = 0; g < 7; g++) begin
      write_gain(gains[g]);
      for (int n = 0; n < 22; n++) begin
        next_sample(si, sq);
        send_sample(si, sq);
      end
      end_stream();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering transactions
  task automatic test_output_holdoff();
    logic signed [SW-1:0] si, sq;
    write_gain(GW'($urandom));
    hold_left = HOLD_CYCLES;
    for (int n = 0; n < 16; n++) begin
      next_sample(si, sq);
      send_sample(si, sq);
    end
    end_stream();
  endtask

  // Long mixed stream, gain changes between phases, one stretch without gaps
  task automatic test_random_stream();
    logic signed [SW-1:0] si, sq;
    for (int n = 0; n < 1300; n++) begin
      if (n % 260 == 0) begin
        end_stream();
        write_gain((n == 520) ? 16'hFFFF : 16'($urandom));
      end
      idle_en = !(n >= 300 && n < 500);
      next_sample(si, sq);
      send_sample(si, sq);
    end
    idle_en = 1'b1;
    end_stream();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_samples();
    test_gain_settings();
    test_output_holdoff();
    test_random_stream();

    wait_idle();
    if (exp_demod_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", exp_demod_q.size()));

    $display("Run covered %0d samples and %0d checked results over %0d gain writes,",
             samples_sent, results_checked, gains_used);
    $display("including axis and zero samples, gain extremes, FM phasors and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fmqd_pkg.sv
rtl/fmqd_cordic.sv
rtl/fmqd_scale.sv
rtl/fm_quadrature_demodulator_top.sv
rtl/fmqd_checker.sv
test/fm_quadrature_demodulator_top_tb.sv
